/* src/tpt_pkg.sv */
// Shared types, constants and helpers for the trapezoid profile timing block.
`timescale 1ns / 1ps

package tpt_pkg;

  localparam int INTER_W = 64;

  typedef logic [INTER_W-1:0] inter_t;

  typedef enum logic {
    REG_MAX_RATE  = 1'b0,
    REG_MAX_ACCEL = 1'b1
  } reg_idx_t;

  // Side data that rides along the square root chain.
  typedef struct packed {
    logic   ramp;
    inter_t tacc;
    inter_t tq;
  } side_t;

  function automatic inter_t sat_add(inter_t a, inter_t b);
    logic [INTER_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[INTER_W] ? '1 : s[INTER_W-1:0];
  endfunction

endpackage

/* src/tpt_div_cell.sv */
// One restoring division step: produces one quotient bit per cycle.
`timescale 1ns / 1ps

module tpt_div_cell #(
  parameter int DW = 31,
  parameter int QW = 49
) (
  input  logic          clk,
  input  logic [DW-1:0] den,
  input  logic [DW-1:0] rem_in,
  input  logic [QW-1:0] x_in,
  output logic [DW-1:0] rem_out,
  output logic [QW-1:0] x_out
);

  logic [DW:0] t;
  logic [DW:0] diff;
  logic        ge;

  always_comb begin
    t    = {rem_in, x_in[QW-1]};
    ge   = (t >= {1'b0, den});
    diff = t - {1'b0, den};
  end

  // The dividend shifts out at the top while quotient bits fill in below.
  always_ff @(posedge clk) begin
    rem_out <= ge ? diff[DW-1:0] : t[DW-1:0];
    x_out   <= {x_in[QW-2:0], ge};
  end

endmodule

/* src/tpt_sqrt_cell.sv */
// One digit-by-digit square root step, carrying the timing side data along.
`timescale 1ns / 1ps

module tpt_sqrt_cell #(
  parameter int P  = 40,
  parameter int ZW = 80
) (
  input  logic            clk,
  input  logic [P-1:0]    root_in,
  input  logic [P+2:0]    rem_in,
  input  logic [ZW-1:0]   z_in,
  input  tpt_pkg::side_t  side_in,
  output logic [P-1:0]    root_out,
  output logic [P+2:0]    rem_out,
  output logic [ZW-1:0]   z_out,
  output tpt_pkg::side_t  side_out
);

  localparam int RW = P + 3;

  logic [RW-1:0] t;
  logic [RW-1:0] trial;
  logic          ge;

  always_comb begin
    t     = {rem_in[RW-3:0], z_in[ZW-1 -: 2]};
    trial = RW'({root_in, 2'b01});
    ge    = (t >= trial);
  end

  always_ff @(posedge clk) begin
    root_out <= {root_in[P-2:0], ge};
    rem_out  <= ge ? (t - trial) : t;
    z_out    <= z_in << 2;
    side_out <= side_in;
  end

endmodule

/* src/trapezoid_profile_timing.sv */
// Top level of the trapezoid profile timing block.
`timescale 1ns / 1ps

// Plans the end times of the accelerate, coast and decelerate phases for a move from
// start_angle to target_angle. A request is taken on any cycle with start high; busy
// is always low and a new request may enter every cycle. The result appears on the
// three time ports with done high for one cycle, after passing through the input
// register, the bit-per-cell divider chain, the quotient register, the digit-per-cell
// square root chain and the two output registers. The result word cannot be held off.
// max_rate and max_accel are written over the APB port and must only change while no
// request is in flight.
module trapezoid_profile_timing #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32,
  localparam int CW  = WORD_BITS - 1,
  localparam int PDW = (CW > 32) ? 64 : 32,
  localparam int AW  = (CW > 32) ? 4 : 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [WORD_BITS-1:0] target_angle,
  input  logic signed [WORD_BITS-1:0] start_angle,
  output logic                        done,
  output logic [WORD_BITS-1:0]        ramp_end_time,
  output logic [WORD_BITS-1:0]        coast_end_time,
  output logic [WORD_BITS-1:0]        finish_time,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [AW-1:0]               paddr,
  input  logic [PDW-1:0]              pwdata,
  output logic [PDW-1:0]              prdata,
  output logic                        pready
);

  localparam int NW    = WORD_BITS + 1;
  localparam int QW    = NW + FRAC_BITS;
  localparam int EW    = (QW > 64) ? QW : 64;
  localparam int PAIRS = (64 + FRAC_BITS + 1) / 2;
  localparam int ZW    = 2 * PAIRS;
  localparam int RW    = PAIRS + 3;
  localparam int N     = QW + PAIRS + 4;

  // Configuration registers.
  logic [CW-1:0] max_rate;
  logic [CW-1:0] max_accel;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_rate  <= CW'(64'd1 << FRAC_BITS);
      max_accel <= CW'(64'd1 << FRAC_BITS);
    end else if (psel && penable && pwrite && pready) begin
      unique case (tpt_pkg::reg_idx_t'(paddr[AW-1]))
        tpt_pkg::REG_MAX_RATE:  max_rate  <= pwdata[CW-1:0];
        tpt_pkg::REG_MAX_ACCEL: max_accel <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (tpt_pkg::reg_idx_t'(paddr[AW-1]))
      tpt_pkg::REG_MAX_RATE:  prdata = {{(PDW-CW){1'b0}}, max_rate};
      tpt_pkg::REG_MAX_ACCEL: prdata = {{(PDW-CW){1'b0}}, max_accel};
      default:                prdata = '0;
    endcase
  end

  // Valid shift line alongside the datapath.
  logic [N-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[N-2:0], start && !busy};
    end
  end

  assign done = vld[N-1];

  // Input stage and distance.
  logic signed [WORD_BITS-1:0] tgt_s0;
  logic signed [WORD_BITS-1:0] sta_s0;
  logic signed [WORD_BITS:0]   diff;
  logic [WORD_BITS-1:0]        dabs;

  always_ff @(posedge clk) begin
    tgt_s0 <= target_angle;
    sta_s0 <= start_angle;
  end

  always_comb begin
    diff = {tgt_s0[WORD_BITS-1], tgt_s0} - {sta_s0[WORD_BITS-1], sta_s0};
    dabs = diff[WORD_BITS] ? WORD_BITS'(-diff) : diff[WORD_BITS-1:0];
  end

  // Three divider lanes: rate/accel, d/rate and 2d/accel.
  logic [CW-1:0] den  [3];
  logic [CW-1:0] drem [3][QW+1];
  logic [QW-1:0] dx   [3][QW+1];

  always_comb begin
    den[0] = max_accel;
    den[1] = max_rate;
    den[2] = max_accel;
    for (int l = 0; l < 3; l++) begin
      drem[l][0] = '0;
    end
    dx[0][0] = QW'(max_rate) << FRAC_BITS;
    dx[1][0] = QW'(dabs) << FRAC_BITS;
    dx[2][0] = QW'({dabs, 1'b0}) << FRAC_BITS;
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    for (genvar s = 0; s < QW; s++) begin : g_div
      tpt_div_cell #(
        .DW(CW),
        .QW(QW)
      ) u_div (
        .clk    (clk),
        .den    (den[l]),
        .rem_in (drem[l][s]),
        .x_in   (dx[l][s]),
        .rem_out(drem[l][s+1]),
        .x_out  (dx[l][s+1])
      );
    end
  end

  // Saturate quotients to the intermediate width; a zero divisor gives all ones.
  logic [EW-1:0]       q_ext [3];
  tpt_pkg::inter_t     q_sat [3];
  tpt_pkg::inter_t     half_a;
  tpt_pkg::inter_t     tq_a;
  tpt_pkg::inter_t     y_a;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      q_ext[l] = EW'(dx[l][QW]);
      q_sat[l] = ((q_ext[l] >> 64) != '0) ? '1 : q_ext[l][63:0];
    end
  end

  always_ff @(posedge clk) begin
    half_a <= (max_accel == '0) ? '1 : q_sat[0];
    tq_a   <= (max_rate == '0) ? '1 : q_sat[1];
    y_a    <= (max_accel == '0) ? '1 : q_sat[2];
  end

  // Ramp time and coast test feed the square root chain.
  logic [PAIRS-1:0]   sroot [PAIRS+1];
  logic [RW-1:0]      srem  [PAIRS+1];
  logic [ZW-1:0]      sz    [PAIRS+1];
  tpt_pkg::side_t     sside [PAIRS+1];
  tpt_pkg::inter_t    tacc_b;

  always_comb begin
    tacc_b         = tpt_pkg::sat_add(half_a, half_a);
    sside[0].ramp  = (tq_a <= tacc_b);
    sside[0].tacc  = tacc_b;
    sside[0].tq    = tq_a;
    sroot[0]       = '0;
    srem[0]        = '0;
    sz[0]          = ZW'(y_a) << FRAC_BITS;
  end

  for (genvar s = 0; s < PAIRS; s++) begin : g_sqrt
    tpt_sqrt_cell #(
      .P (PAIRS),
      .ZW(ZW)
    ) u_sqrt (
      .clk     (clk),
      .root_in (sroot[s]),
      .rem_in  (srem[s]),
      .z_in    (sz[s]),
      .side_in (sside[s]),
      .root_out(sroot[s+1]),
      .rem_out (srem[s+1]),
      .z_out   (sz[s+1]),
      .side_out(sside[s+1])
    );
  end

  // Select the branch, then form and clamp the three times.
  tpt_pkg::inter_t tacc_sel;
  tpt_pkg::inter_t tacc_f;
  tpt_pkg::inter_t tacc2_f;
  tpt_pkg::inter_t tv_f;
  tpt_pkg::inter_t sum1;
  tpt_pkg::inter_t sum2;

  always_comb begin
    tacc_sel = sside[PAIRS].ramp ? tpt_pkg::inter_t'(sroot[PAIRS]) : sside[PAIRS].tacc;
    sum1     = tpt_pkg::sat_add(tacc_f, tv_f);
    sum2     = tpt_pkg::sat_add(tacc2_f, tv_f);
  end

  always_ff @(posedge clk) begin
    tacc_f  <= tacc_sel;
    tacc2_f <= tpt_pkg::sat_add(tacc_sel, tacc_sel);
    tv_f    <= sside[PAIRS].ramp ? '0 : (sside[PAIRS].tq - sside[PAIRS].tacc);
  end

  always_ff @(posedge clk) begin
    ramp_end_time  <= (tacc_f[63:WORD_BITS] != '0) ? '1 : tacc_f[WORD_BITS-1:0];
    coast_end_time <= (sum1[63:WORD_BITS] != '0) ? '1 : sum1[WORD_BITS-1:0];
    finish_time    <= (sum2[63:WORD_BITS] != '0) ? '1 : sum2[WORD_BITS-1:0];
  end

`ifndef ASSERT_OFF
  a_coast_after_ramp: assert property (@(posedge clk) disable iff (rst)
    done |-> coast_end_time >= ramp_end_time)
    else $error("coast end precedes ramp end");

  a_finish_after_coast: assert property (@(posedge clk) disable iff (rst)
    done |-> finish_time >= coast_end_time)
    else $error("finish precedes coast end");

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##N done)
    else $error("result word missing after fixed latency");
`endif

endmodule
